[rtl/core/amc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amc_pkg
// Types, codes and helpers shared by the box move-and-collide block.
// ---------------------------------------------------------------------------
package amc_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [1:0] SIDE_TOP    = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [1:0] SIDE_LEFT   = 2'd3;

    localparam logic [1:0] CODE_NONE = 2'd0;
    localparam logic [1:0] CODE_X    = 2'd1;
    localparam logic [1:0] CODE_Y    = 2'd2;

    localparam int MF_NO_PHYS   = 0;
    localparam int MF_GRAVITY   = 1;
    localparam int MF_COLLIDES  = 2;
    localparam int MF_PUSHED    = 3;
    localparam int MF_WALLS     = 4;
    localparam int MF_PRIOR_GND = 5;

    localparam logic CFG_GRAVITY    = 1'b0;
    localparam logic CFG_FALL_LIMIT = 1'b1;

    localparam logic [7:0]  GRAVITY_RST    = 8'd1;
    localparam logic [14:0] FALL_LIMIT_RST = 15'd8;

    typedef struct packed {
        logic               operation;
        logic [3:0]         slot;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [9:0]         half_w;
        logic [9:0]         half_h;
        logic               blocks;
        logic               is_wall;
        logic signed [15:0] speed_x;
        logic signed [15:0] speed_y;
        logic [5:0]         mode_flags;
    } req_t;

    typedef struct packed {
        logic               is_final;
        logic [1:0]         side;
        logic [3:0]         hit_slot;
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
        logic signed [15:0] new_speed_x;
        logic signed [15:0] new_speed_y;
        logic               on_ground;
        logic [1:0]         collided_code;
    } rsp_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [9:0]         hw;
        logic [9:0]         hh;
        logic               blk;
        logic               wall;
    } box_t;

    localparam int BOX_W = $bits(box_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SELF,
        ST_XSCAN,
        ST_YMOVE,
        ST_YSCAN,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic capture;
        logic load_wr;
        logic self_ld;
        logic scan_rst;
        logic scan_step;
        logic pass_y;
        logic y_move;
        logic final_emit;
    } cmd_t;

    typedef struct packed {
        logic step_ok;
        logic is_step;
        logic nophys;
        logic collide;
        logic last_j;
        logic stall;
        logic out_free;
    } sts_t;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
            r = 16'sh7FFF;
        else if (v < -18'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

[rtl/core/amc_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module amc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

[rtl/core/amc_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amc_ctrl
// Sequencer: load, or self read, x move and scan, y move and scan, final word.
// ---------------------------------------------------------------------------
module amc_ctrl
    import amc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_ready,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && sts.is_step && sts.step_ok)
                    state_next = ST_SELF;
            end
            ST_SELF:
            begin
                if (sts.nophys)
                    state_next = ST_FINAL;
                else if (sts.collide)
                    state_next = ST_XSCAN;
                else
                    state_next = ST_YMOVE;
            end
            ST_XSCAN:
            begin
                if (!sts.stall && sts.last_j)
                    state_next = ST_YMOVE;
            end
            ST_YMOVE:
            begin
                state_next = sts.collide ? ST_YSCAN : ST_FINAL;
            end
            ST_YSCAN:
            begin
                if (!sts.stall && sts.last_j)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
                cmd.load_wr = req_valid && !sts.is_step && sts.step_ok;
            end
            ST_SELF:
            begin
                cmd.self_ld  = 1'b1;
                cmd.scan_rst = !sts.nophys && sts.collide;
            end
            ST_XSCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_YMOVE:
            begin
                cmd.y_move   = 1'b1;
                cmd.scan_rst = sts.collide;
            end
            ST_YSCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.pass_y    = 1'b1;
            end
            ST_FINAL:
            begin
                cmd.final_emit = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/core/amc_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// amc_dp
// Mover registers, overlap test, push-out, valid bits, output register.
// ---------------------------------------------------------------------------
module amc_dp
    import amc_pkg::*;
#(
    parameter int MAX_BOXES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  req_t                         req,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [14:0]                  cfg_data,
    input  cmd_t                         cmd,
    output sts_t                         sts,
    output logic                         ram_we,
    output logic [$clog2(MAX_BOXES)-1:0] ram_waddr,
    output box_t                         ram_wdata,
    output logic                         ram_re,
    output logic [$clog2(MAX_BOXES)-1:0] ram_raddr,
    input  box_t                         ram_rdata,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output rsp_t                         rsp
);

    localparam int IW = $clog2(MAX_BOXES);
    localparam logic [IW-1:0] LAST_J = IW'(MAX_BOXES - 1);

    logic [7:0]           gravity_reg;
    logic [14:0]          limit_reg;
    logic [MAX_BOXES-1:0] valid_reg;
    logic                 out_valid_reg;
    rsp_t                 out_reg;

    logic [IW-1:0]        s_reg, j_reg;
    logic signed [15:0]   sx_in_reg, sy_in_reg;
    logic [5:0]           mf_reg;
    box_t                 self_reg;

    logic signed [15:0]   x_reg, x_next, y_reg, y_next;
    logic signed [15:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic                 gnd_reg, gnd_next;
    logic [1:0]           code_reg, code_next;

    logic                 slot_ok, out_free, cand, push_ok, hit, fire, final_fire;
    logic signed [17:0]   xs, ys, hws, hhs, exs, eys, ehws, ehhs;
    logic signed [17:0]   sy_g, lim;
    rsp_t                 word;

    assign slot_ok  = 32'(req.slot) < MAX_BOXES;
    assign out_free = !out_valid_reg || rsp_ready;

    assign xs   = 18'(x_reg);
    assign ys   = 18'(y_reg);
    assign hws  = $signed({8'd0, self_reg.hw});
    assign hhs  = $signed({8'd0, self_reg.hh});
    assign exs  = 18'(ram_rdata.x);
    assign eys  = 18'(ram_rdata.y);
    assign ehws = $signed({8'd0, ram_rdata.hw});
    assign ehhs = $signed({8'd0, ram_rdata.hh});
    assign lim  = $signed({3'd0, limit_reg});
    assign sy_g = 18'(sy_in_reg) + $signed({10'd0, gravity_reg});

    always_comb
    begin
        cand = (j_reg != s_reg) && valid_reg[j_reg]
            && (!cmd.pass_y || ram_rdata.blk)
            && (xs - hws < exs + ehws) && (xs + hws > exs - ehws)
            && (ys - hhs < eys + ehhs) && (ys + hhs > eys - ehhs);
        push_ok = mf_reg[MF_PUSHED] && ram_rdata.blk
            && (!mf_reg[MF_WALLS] || ram_rdata.wall);
        hit        = cmd.scan_step && cand;
        fire       = hit && out_free;
        final_fire = cmd.final_emit && out_free;
    end

    // mover update
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        gnd_next  = gnd_reg;
        code_next = code_reg;
        if (cmd.self_ld)
        begin
            y_next    = ram_rdata.y;
            sx_next   = sx_in_reg;
            gnd_next  = mf_reg[MF_PRIOR_GND];
            code_next = CODE_NONE;
            if (mf_reg[MF_NO_PHYS])
            begin
                x_next  = ram_rdata.x;
                sy_next = sy_in_reg;
            end
            else
            begin
                x_next = sat16(18'(ram_rdata.x) + 18'(sx_in_reg));
                if (mf_reg[MF_GRAVITY])
                begin
                    sy_next  = (sy_g > lim) ? lim[15:0] : sy_g[15:0];
                    gnd_next = 1'b0;
                end
                else
                begin
                    sy_next = sy_in_reg;
                end
            end
        end
        else if (cmd.y_move)
        begin
            y_next = sat16(ys + 18'(sy_reg));
        end
        else if (fire)
        begin
            if (!cmd.pass_y)
            begin
                code_next = CODE_X;
                if (push_ok)
                begin
                    x_next  = (sx_reg >= 0) ? sat16(exs - ehws - hws)
                                            : sat16(exs + ehws + hws);
                    sx_next = '0;
                end
            end
            else
            begin
                code_next = CODE_Y;
                if (push_ok)
                begin
                    if (sy_reg >= 0)
                    begin
                        y_next   = sat16(eys - ehhs - hhs);
                        gnd_next = 1'b1;
                    end
                    else
                    begin
                        y_next = sat16(eys + ehhs + hhs);
                    end
                    sy_next = '0;
                end
            end
        end
    end

    always_comb
    begin
        word = '0;
        if (cmd.final_emit)
        begin
            word.is_final      = 1'b1;
            word.new_x         = x_reg;
            word.new_y         = y_reg;
            word.new_speed_x   = sx_reg;
            word.new_speed_y   = sy_reg;
            word.on_ground     = gnd_reg;
            word.collided_code = code_reg;
        end
        else
        begin
            word.hit_slot = 4'(j_reg);
            if (cmd.pass_y)
                word.side = (sy_reg >= 0) ? SIDE_BOTTOM : SIDE_TOP;
            else
                word.side = (sx_reg >= 0) ? SIDE_RIGHT : SIDE_LEFT;
        end
    end

    // table access
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = j_reg + 1'b1;
        if (cmd.capture)
        begin
            ram_re    = 1'b1;
            ram_raddr = IW'(req.slot);
        end
        else if (cmd.scan_rst)
        begin
            ram_re    = 1'b1;
            ram_raddr = '0;
        end
        else if (cmd.scan_step && !(hit && !out_free) && j_reg != LAST_J)
        begin
            ram_re = 1'b1;
        end
        ram_we    = cmd.load_wr || final_fire;
        ram_waddr = cmd.load_wr ? IW'(req.slot) : s_reg;
        if (cmd.load_wr)
        begin
            ram_wdata.x    = req.pos_x;
            ram_wdata.y    = req.pos_y;
            ram_wdata.hw   = req.half_w;
            ram_wdata.hh   = req.half_h;
            ram_wdata.blk  = req.blocks;
            ram_wdata.wall = req.is_wall;
        end
        else
        begin
            ram_wdata   = self_reg;
            ram_wdata.x = x_reg;
            ram_wdata.y = y_reg;
        end
    end

    always_comb
    begin
        sts.step_ok  = slot_ok;
        sts.is_step  = req.operation == OP_STEP;
        sts.nophys   = mf_reg[MF_NO_PHYS];
        sts.collide  = mf_reg[MF_COLLIDES];
        sts.last_j   = j_reg == LAST_J;
        sts.stall    = hit && !out_free;
        sts.out_free = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg   <= GRAVITY_RST;
            limit_reg     <= FALL_LIMIT_RST;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_GRAVITY)
                gravity_reg <= cfg_data[7:0];
            if (cfg_we && cfg_index == CFG_FALL_LIMIT)
                limit_reg <= cfg_data;
            if (cmd.load_wr)
                valid_reg[IW'(req.slot)] <= 1'b1;
            if (fire || final_fire)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            s_reg     <= IW'(req.slot);
            sx_in_reg <= req.speed_x;
            sy_in_reg <= req.speed_y;
            mf_reg    <= req.mode_flags;
        end
        if (cmd.self_ld)
            self_reg <= ram_rdata;
        if (cmd.scan_rst)
            j_reg <= '0;
        else if (cmd.scan_step && !(hit && !out_free) && j_reg != LAST_J)
            j_reg <= j_reg + 1'b1;
        if (fire || final_fire)
            out_reg <= word;
        x_reg    <= x_next;
        y_reg    <= y_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        gnd_reg  <= gnd_next;
        code_reg <= code_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

[rtl/core/aabb_move_and_collide.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aabb_move_and_collide
// Box table with axis-separated move, overlap test and push-out.
// ---------------------------------------------------------------------------
// A load word is written to the table in the cycle it is accepted. A step
// word runs self read and x move, x scan, y move, y scan and final word;
// no new word is accepted meanwhile. Scans run only with collisions on;
// physics off goes from self read straight to the final word. The single
// read port of the box table reads each slot once per scan, one slot a
// cycle; collision and final words wait while the output is full, untaken.
// Collision words leave in slot order, x pass first, then the final word.
module aabb_move_and_collide
    import amc_pkg::*;
#(
    parameter int MAX_BOXES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [14:0] cfg_data
);

    localparam int IW = $clog2(MAX_BOXES);

    cmd_t          cmd;
    sts_t          sts;
    logic          ram_we, ram_re;
    logic [IW-1:0] ram_waddr, ram_raddr;
    box_t          ram_wdata, ram_rdata;

    amc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    amc_dp #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    amc_ram #(
        .WIDTH (BOX_W),
        .DEPTH (MAX_BOXES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    a_load_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_wr |-> cmd.capture)
        else $error("table load outside an accepted word");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.self_ld, cmd.y_move, cmd.scan_step, cmd.final_emit}))
        else $error("more than one sequencer command");

    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && sts.is_step && sts.step_ok) |=> !req_ready)
        else $error("step accepted but sequencer stayed idle");

endmodule
